@@ design/baro_temp_pressure_compensation_defines.svh @@
// ---------------------------------------------------------------------------
// baro temp pressure compensation assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BTPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/btpc_pkg.sv @@
// ---------------------------------------------------------------------------
// btpc_pkg
// constants and helpers for the barometric compensation block
// ---------------------------------------------------------------------------
`default_nettype none
package btpc_pkg;
	localparam int unsigned W = 32;
	localparam int unsigned CNT_W = $clog2(W);
	localparam int unsigned RAW_W = 19;
	localparam int unsigned CFG_W = 64;
	localparam int unsigned IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_COEFF_A = 2'd0;
	localparam logic [IDX_W-1:0] REG_COEFF_B = 2'd1;
	localparam logic [IDX_W-1:0] REG_COEFF_C = 2'd2;
	localparam logic [IDX_W-1:0] REG_OSS     = 2'd3;

	localparam logic [W-1:0] K_B6_OFS   = 32'd4000;
	localparam logic [W-1:0] K_B7_SCALE = 32'd50000;
	localparam logic [W-1:0] K_HALF     = 32'h8000_0000;
	localparam logic [W-1:0] K_B4_OFS   = 32'd32768;
	localparam logic [W-1:0] K_P_C1     = 32'd3038;
	localparam logic [W-1:0] K_P_C2     = 32'hFFFF_E343;
	localparam logic [W-1:0] K_P_C3     = 32'd3791;

	typedef logic [W-1:0] word_t;

	function automatic word_t sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic word_t ux16(input logic [15:0] v);
		return {16'd0, v};
	endfunction

	function automatic word_t asr(input word_t v, input logic [4:0] s);
		return word_t'($signed(v) >>> s);
	endfunction
endpackage
`default_nettype wire

@@ design/baro_temp_pressure_compensation.sv @@
// ---------------------------------------------------------------------------
// baro_temp_pressure_compensation
// temperature and pressure compensation on a shared serial multiplier
// and serial divider, driven by a step sequencer
// ---------------------------------------------------------------------------
// channel  handshake           payload
// in       in_valid/in_stall   command, raw_value
// out      out_valid/out_stall result_kind, result_value, divide_fault
// cfg      cfg_we              cfg_index, cfg_data
//
// each multiply or divide step is one pass through the serial units
// temperature: two passes from input transfer to out_valid
// pressure: eleven passes
// zero divisor ends early, with divide_fault set
// the ST_OUT state moves the result to the output register
// reset clears control state; out_stall only delays the final transfer
// ---------------------------------------------------------------------------
`default_nettype none
module baro_temp_pressure_compensation
	import btpc_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 command,
	input  wire  [RAW_W-1:0]    raw_value,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic                result_kind,
	output logic signed [W-1:0] result_value,
	output logic                divide_fault,
	input  wire                 cfg_we,
	input  wire  [IDX_W-1:0]    cfg_index,
	input  wire  [CFG_W-1:0]    cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam logic [3:0] T1  = 4'd0;
	localparam logic [3:0] T2  = 4'd1;
	localparam logic [3:0] P1  = 4'd2;
	localparam logic [3:0] P2  = 4'd3;
	localparam logic [3:0] P3  = 4'd4;
	localparam logic [3:0] P4  = 4'd5;
	localparam logic [3:0] P5  = 4'd6;
	localparam logic [3:0] P6  = 4'd7;
	localparam logic [3:0] P7  = 4'd8;
	localparam logic [3:0] P8  = 4'd9;
	localparam logic [3:0] P9  = 4'd10;
	localparam logic [3:0] P10 = 4'd11;
	localparam logic [3:0] P11 = 4'd12;

	logic [CFG_W-1:0] coef_a_q, coef_b_q;
	word_t coef_c_q;
	logic [1:0] oss_q;
	word_t ti_q;

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic kind_q;
	logic [RAW_W-1:0] raw_q;
	word_t x1_q, b6_q, sq_q, b3_q, b4_q, p_q;
	logic neg_q, sft_q;
	word_t pend_val_q;
	logic pend_flt_q;
	logic out_valid_q, kind_out_q, flt_out_q;
	word_t val_out_q;

	word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(coef_a_q[63:48]);
	assign ac2 = sx16(coef_a_q[47:32]);
	assign ac3 = sx16(coef_a_q[31:16]);
	assign ac4 = ux16(coef_a_q[15:0]);
	assign ac5 = ux16(coef_b_q[63:48]);
	assign ac6 = ux16(coef_b_q[47:32]);
	assign b1  = sx16(coef_b_q[31:16]);
	assign b2  = sx16(coef_b_q[15:0]);
	assign mc  = sx16(coef_c_q[31:16]);
	assign md  = sx16(coef_c_q[15:0]);

	logic mul_go, div_go, mul_done, div_done, unit_done;
	word_t mul_a, mul_b, div_n, div_d, prod, quo;

	btpc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
	);

	btpc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(div_n), .den(div_d), .done(div_done), .quo(quo)
	);

	logic accept, out_free, run_done;
	assign accept    = in_valid && !in_stall;
	assign unit_done = mul_done || div_done;
	assign run_done  = (state_q == ST_RUN) && unit_done;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// step datapath
	word_t x1t, den_t, num_t, qs, b5, tv, x3a, b3t, x1b, x3b, p_t, pa, fin_p;
	word_t b6_in;
	assign b6_in = ti_q - K_B6_OFS;
	assign x1t   = asr(prod, 5'd15);
	assign den_t = x1t + md;
	assign num_t = {mc[20:0], 11'd0};
	assign qs    = neg_q ? (word_t'(0) - quo) : quo;
	assign b5    = x1_q + qs;
	assign tv    = asr(b5 + 32'd8, 5'd4);
	assign x3a   = x1_q + asr(prod, 5'd11);
	assign b3t   = asr(((word_t'(ac1 << 2) + x3a) << oss_q) + 32'd2, 5'd2);
	assign x1b   = asr(prod, 5'd13);
	assign x3b   = asr(x1_q + asr(prod, 5'd16) + 32'd2, 5'd2);
	assign p_t   = sft_q ? {quo[W-2:0], 1'b0} : quo;
	assign pa    = asr(p_t, 5'd8);
	assign fin_p = p_q + asr(x1_q + asr(prod, 5'd16) + K_P_C3, 5'd4);

	logic fin, fin_flt;
	word_t fin_val;

	always_comb begin
		mul_go  = 1'b0;
		div_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_n   = '0;
		div_d   = '0;
		fin     = 1'b0;
		fin_flt = 1'b0;
		fin_val = '0;
		if (accept) begin
			mul_go = 1'b1;
			if (command) begin
				mul_a = b6_in;
				mul_b = b6_in;
			end else begin
				mul_a = word_t'(raw_value) - ac6;
				mul_b = ac5;
			end
		end else if (run_done) begin
			case (step_q)
				T1: begin
					if (den_t == '0) begin
						fin     = 1'b1;
						fin_flt = 1'b1;
					end else begin
						div_go = 1'b1;
						div_n  = num_t[W-1] ? (word_t'(0) - num_t) : num_t;
						div_d  = den_t[W-1] ? (word_t'(0) - den_t) : den_t;
					end
				end
				T2: begin
					fin     = 1'b1;
					fin_val = sx16(tv[15:0]);
				end
				P1: begin
					mul_go = 1'b1;
					mul_a  = asr(prod, 5'd12);
					mul_b  = b2;
				end
				P2: begin
					mul_go = 1'b1;
					mul_a  = ac2;
					mul_b  = b6_q;
				end
				P3: begin
					mul_go = 1'b1;
					mul_a  = ac3;
					mul_b  = b6_q;
				end
				P4: begin
					mul_go = 1'b1;
					mul_a  = b1;
					mul_b  = sq_q;
				end
				P5: begin
					mul_go = 1'b1;
					mul_a  = ac4;
					mul_b  = x3b + K_B4_OFS;
				end
				P6: begin
					mul_go = 1'b1;
					mul_a  = word_t'(raw_q) - b3_q;
					mul_b  = K_B7_SCALE >> oss_q;
				end
				P7: begin
					if (b4_q == '0) begin
						fin     = 1'b1;
						fin_flt = 1'b1;
					end else begin
						div_go = 1'b1;
						div_n  = (prod < K_HALF) ? {prod[W-2:0], 1'b0} : prod;
						div_d  = b4_q;
					end
				end
				P8: begin
					mul_go = 1'b1;
					mul_a  = pa;
					mul_b  = pa;
				end
				P9: begin
					mul_go = 1'b1;
					mul_a  = prod;
					mul_b  = K_P_C1;
				end
				P10: begin
					mul_go = 1'b1;
					mul_a  = p_q;
					mul_b  = K_P_C2;
				end
				P11: begin
					fin     = 1'b1;
					fin_val = fin_p;
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			oss_q    <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEFF_A: coef_a_q <= cfg_data;
				REG_COEFF_B: coef_b_q <= cfg_data;
				REG_COEFF_C: coef_c_q <= cfg_data[W-1:0];
				REG_OSS:     oss_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= T1;
			ti_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= command ? P1 : T1;
					end
				end
				ST_RUN: begin
					if (run_done) begin
						if (fin) state_q <= ST_OUT;
						else step_q <= step_q + 4'd1;
						if (step_q == T2) ti_q <= b5;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= command;
			raw_q  <= raw_value;
			b6_q   <= b6_in;
		end
		if (run_done) begin
			case (step_q)
				T1: begin
					x1_q  <= x1t;
					neg_q <= num_t[W-1] ^ den_t[W-1];
				end
				P1: sq_q <= asr(prod, 5'd12);
				P2: x1_q <= asr(prod, 5'd11);
				P3: begin
					b3_q <= b3t;
				end
				P4: x1_q <= x1b;
				P6: b4_q <= prod >> 15;
				P7: sft_q <= !(prod < K_HALF);
				P8: p_q <= p_t;
				P10: x1_q <= asr(prod, 5'd16);
				default: ;
			endcase
			if (fin) begin
				pend_val_q <= fin_val;
				pend_flt_q <= fin_flt;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			kind_out_q <= kind_q;
			val_out_q  <= pend_val_q;
			flt_out_q  <= pend_flt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_out_q;
	assign result_value = $signed(val_out_q);
	assign divide_fault = flt_out_q;
endmodule
`default_nettype wire

@@ design/btpc_mul.sv @@
// ---------------------------------------------------------------------------
// btpc_mul
// bit-serial shift-add multiplier, low 32 bits of the product
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_mul
	import btpc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire word_t a,
	input  wire word_t b,
	output logic       done,
	output word_t      prod
);
	word_t a_q, b_q, acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

@@ design/btpc_div.sv @@
// ---------------------------------------------------------------------------
// btpc_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_div
	import btpc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire word_t num,
	input  wire word_t den,
	output logic       done,
	output word_t      quo
);
	word_t rem_q, quo_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W:0] trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

@@ design/btpc_checker.sv @@
// ---------------------------------------------------------------------------
// btpc_checker
// port-level checks for the barometric compensation block
// ---------------------------------------------------------------------------
`default_nettype none
`include "baro_temp_pressure_compensation_defines.svh"
module btpc_checker
	import btpc_pkg::*;
(
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input wire signed [W-1:0]  result_value,
	input wire                 divide_fault
);
	// a faulted result always reads zero
	`BTPC_ASSERT_NOW(a_fault_zero, out_valid && divide_fault, result_value == '0, "fault nonzero")
	// the block is busy right after an input transfer
	`BTPC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "not busy after input")
	// a stalled result stays offered
	`BTPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (.*);
`default_nettype wire
